// File: rtl/rgbhsv_pkg.sv
// Shared constants and types for the RGB to HSV converter.
`default_nettype none

package rgbhsv_pkg;

	localparam int unsigned CHANNEL_BITS_DEF = 8;
	localparam int unsigned QUO_BITS         = 16;
	localparam int unsigned STEPS_PER_STAGE  = 2;
	localparam int unsigned DIV_STAGES       = QUO_BITS / STEPS_PER_STAGE;

	localparam int unsigned GREEN_OFFSET = 2;
	localparam int unsigned BLUE_OFFSET  = 4;
	localparam int unsigned HUE_SECTORS  = 6;

	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} max_sel_t;

endpackage

`default_nettype wire

// File: rtl/rgbhsv_front.sv
// First pipeline stage: max, min, hue numerator and divider operands.
`default_nettype none

module rgbhsv_front #(
	parameter int unsigned CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      valid_in,
	output logic                           ready_up,
	input  wire logic [CHANNEL_BITS-1:0]   red,
	input  wire logic [CHANNEL_BITS-1:0]   green,
	input  wire logic [CHANNEL_BITS-1:0]   blue,
	output logic                           valid_s1,
	input  wire logic                      ready_dn,
	output logic                           flat_s1,
	output logic [CHANNEL_BITS-1:0]        value_s1,
	output logic [CHANNEL_BITS-1:0]        sat_rem_s1,
	output logic [rgbhsv_pkg::QUO_BITS-1:0] sat_low_s1,
	output logic [CHANNEL_BITS-1:0]        sat_div_s1,
	output logic [CHANNEL_BITS+2:0]        hue_rem_s1,
	output logic [CHANNEL_BITS+2:0]        hue_div_s1
);
	import rgbhsv_pkg::*;

	localparam int unsigned CB = CHANNEL_BITS;
	localparam int unsigned NW = CB + 3;

	logic [CB-1:0]          hi;
	logic [CB-1:0]          lo;
	logic [CB-1:0]          d;
	logic [NW-1:0]          r3;
	logic [NW-1:0]          g3;
	logic [NW-1:0]          b3;
	logic [NW-1:0]          d3;
	logic [NW-1:0]          num;
	logic [NW-1:0]          hdiv;
	logic [CB+QUO_BITS-1:0] sat_num;
	max_sel_t               sel;

	always_comb begin
		hi = (red > green) ? red : green;
		hi = (hi > blue) ? hi : blue;
		lo = (red < green) ? red : green;
		lo = (lo < blue) ? lo : blue;
		d  = hi - lo;
		r3 = NW'(red);
		g3 = NW'(green);
		b3 = NW'(blue);
		d3 = NW'(d);
		if (blue == hi) begin
			sel = SEL_BLUE;
		end else if (green == hi) begin
			sel = SEL_GREEN;
		end else begin
			sel = SEL_RED;
		end
		unique case (sel)
			SEL_BLUE:  num = d3 * NW'(BLUE_OFFSET) + r3 - g3;
			SEL_GREEN: num = d3 * NW'(GREEN_OFFSET) + b3 - r3;
			SEL_RED: begin
				if (green >= blue) begin
					num = g3 - b3;
				end else begin
					num = d3 * NW'(HUE_SECTORS) - (b3 - g3);
				end
			end
			default:   num = '0;
		endcase
		hdiv    = d3 * NW'(HUE_SECTORS);
		sat_num = {d, {QUO_BITS{1'b0}}} - {{QUO_BITS{1'b0}}, d};
	end

	assign ready_up = !valid_s1 || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_up) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && valid_in) begin
			flat_s1    <= (d == '0);
			value_s1   <= hi;
			sat_rem_s1 <= sat_num[CB+QUO_BITS-1:QUO_BITS];
			sat_low_s1 <= sat_num[QUO_BITS-1:0];
			sat_div_s1 <= hi;
			hue_rem_s1 <= num;
			hue_div_s1 <= hdiv;
		end
	end

endmodule

`default_nettype wire

// File: rtl/rgbhsv_div_stage.sv
// One divider stage: STEPS_PER_STAGE restoring steps for saturation and hue, then a register.
`default_nettype none

module rgbhsv_div_stage #(
	parameter int unsigned CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        valid_in,
	output logic                             ready_up,
	input  wire logic                        flat_in,
	input  wire logic [CHANNEL_BITS-1:0]     value_in,
	input  wire logic [CHANNEL_BITS-1:0]     sat_rem_in,
	input  wire logic [rgbhsv_pkg::QUO_BITS-1:0] sat_low_in,
	input  wire logic [CHANNEL_BITS-1:0]     sat_div_in,
	input  wire logic [rgbhsv_pkg::QUO_BITS-1:0] sat_quo_in,
	input  wire logic [CHANNEL_BITS+2:0]     hue_rem_in,
	input  wire logic [CHANNEL_BITS+2:0]     hue_div_in,
	input  wire logic [rgbhsv_pkg::QUO_BITS-1:0] hue_quo_in,
	output logic                             valid_q,
	input  wire logic                        ready_dn,
	output logic                             flat_q,
	output logic [CHANNEL_BITS-1:0]          value_q,
	output logic [CHANNEL_BITS-1:0]          sat_rem_q,
	output logic [rgbhsv_pkg::QUO_BITS-1:0]  sat_low_q,
	output logic [CHANNEL_BITS-1:0]          sat_div_q,
	output logic [rgbhsv_pkg::QUO_BITS-1:0]  sat_quo_q,
	output logic [CHANNEL_BITS+2:0]          hue_rem_q,
	output logic [CHANNEL_BITS+2:0]          hue_div_q,
	output logic [rgbhsv_pkg::QUO_BITS-1:0]  hue_quo_q
);
	import rgbhsv_pkg::*;

	localparam int unsigned CB = CHANNEL_BITS;
	localparam int unsigned NW = CB + 3;

	logic [CB-1:0]       s_rem;
	logic [QUO_BITS-1:0] s_low;
	logic [QUO_BITS-1:0] s_quo;
	logic [NW-1:0]       h_rem;
	logic [QUO_BITS-1:0] h_quo;

	always_comb begin
		logic [CB:0] s_t;
		logic [NW:0] h_t;
		s_rem = sat_rem_in;
		s_low = sat_low_in;
		s_quo = sat_quo_in;
		h_rem = hue_rem_in;
		h_quo = hue_quo_in;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			s_t   = {s_rem, s_low[QUO_BITS-1]};
			s_low = {s_low[QUO_BITS-2:0], 1'b0};
			if (s_t >= {1'b0, sat_div_in}) begin
				s_t   = s_t - {1'b0, sat_div_in};
				s_quo = {s_quo[QUO_BITS-2:0], 1'b1};
			end else begin
				s_quo = {s_quo[QUO_BITS-2:0], 1'b0};
			end
			s_rem = s_t[CB-1:0];
			h_t   = {h_rem, 1'b0};
			if (h_t >= {1'b0, hue_div_in}) begin
				h_t   = h_t - {1'b0, hue_div_in};
				h_quo = {h_quo[QUO_BITS-2:0], 1'b1};
			end else begin
				h_quo = {h_quo[QUO_BITS-2:0], 1'b0};
			end
			h_rem = h_t[NW-1:0];
		end
	end

	assign ready_up = !valid_q || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_up) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && valid_in) begin
			flat_q    <= flat_in;
			value_q   <= value_in;
			sat_rem_q <= s_rem;
			sat_low_q <= s_low;
			sat_div_q <= sat_div_in;
			sat_quo_q <= s_quo;
			hue_rem_q <= h_rem;
			hue_div_q <= hue_div_in;
			hue_quo_q <= h_quo;
		end
	end

endmodule

`default_nettype wire

// File: rtl/rgb_to_hsv_converter.sv
// Top level of the pipelined RGB to HSV converter.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+------------------------------------
//  pixel   | pix_valid | pix_ready | red, green, blue
//  result  | hsv_valid | hsv_ready | hue, saturation, value, achromatic
//
// One item per cycle sustained while hsv_ready stays high: one stage for max/min
// and operands, then the two restoring dividers, two quotient bits per stage,
// for 16 quotient bits.
// Reset clears only the stage valid bits.
// Each stage holds while its successor is full and stalled; empty stages keep filling.
`default_nettype none

module rgb_to_hsv_converter #(
	parameter int unsigned CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pix_valid,
	output logic                                 pix_ready,
	input  wire logic [CHANNEL_BITS-1:0]         red,
	input  wire logic [CHANNEL_BITS-1:0]         green,
	input  wire logic [CHANNEL_BITS-1:0]         blue,
	output logic                                 hsv_valid,
	input  wire logic                            hsv_ready,
	output logic [rgbhsv_pkg::QUO_BITS-1:0]      hue,
	output logic [rgbhsv_pkg::QUO_BITS-1:0]      saturation,
	output logic [CHANNEL_BITS-1:0]              value,
	output logic                                 achromatic
);
	import rgbhsv_pkg::*;

	localparam int unsigned CB = CHANNEL_BITS;

	logic                valid_c   [0:DIV_STAGES];
	logic                ready_c   [0:DIV_STAGES];
	logic                flat_c    [0:DIV_STAGES];
	logic [CB-1:0]       value_c   [0:DIV_STAGES];
	logic [CB-1:0]       sat_rem_c [0:DIV_STAGES];
	logic [QUO_BITS-1:0] sat_low_c [0:DIV_STAGES];
	logic [CB-1:0]       sat_div_c [0:DIV_STAGES];
	logic [QUO_BITS-1:0] sat_quo_c [0:DIV_STAGES];
	logic [CB+2:0]       hue_rem_c [0:DIV_STAGES];
	logic [CB+2:0]       hue_div_c [0:DIV_STAGES];
	logic [QUO_BITS-1:0] hue_quo_c [0:DIV_STAGES];

	rgbhsv_front #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_in   (pix_valid),
		.ready_up   (pix_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.valid_s1   (valid_c[0]),
		.ready_dn   (ready_c[0]),
		.flat_s1    (flat_c[0]),
		.value_s1   (value_c[0]),
		.sat_rem_s1 (sat_rem_c[0]),
		.sat_low_s1 (sat_low_c[0]),
		.sat_div_s1 (sat_div_c[0]),
		.hue_rem_s1 (hue_rem_c[0]),
		.hue_div_s1 (hue_div_c[0])
	);

	assign sat_quo_c[0] = '0;
	assign hue_quo_c[0] = '0;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		rgbhsv_div_stage #(
			.CHANNEL_BITS(CHANNEL_BITS)
		) u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.valid_in   (valid_c[k]),
			.ready_up   (ready_c[k]),
			.flat_in    (flat_c[k]),
			.value_in   (value_c[k]),
			.sat_rem_in (sat_rem_c[k]),
			.sat_low_in (sat_low_c[k]),
			.sat_div_in (sat_div_c[k]),
			.sat_quo_in (sat_quo_c[k]),
			.hue_rem_in (hue_rem_c[k]),
			.hue_div_in (hue_div_c[k]),
			.hue_quo_in (hue_quo_c[k]),
			.valid_q    (valid_c[k+1]),
			.ready_dn   (ready_c[k+1]),
			.flat_q     (flat_c[k+1]),
			.value_q    (value_c[k+1]),
			.sat_rem_q  (sat_rem_c[k+1]),
			.sat_low_q  (sat_low_c[k+1]),
			.sat_div_q  (sat_div_c[k+1]),
			.sat_quo_q  (sat_quo_c[k+1]),
			.hue_rem_q  (hue_rem_c[k+1]),
			.hue_div_q  (hue_div_c[k+1]),
			.hue_quo_q  (hue_quo_c[k+1])
		);
	end

	assign ready_c[DIV_STAGES] = hsv_ready;
	assign hsv_valid           = valid_c[DIV_STAGES];
	assign achromatic          = flat_c[DIV_STAGES];
	assign value               = value_c[DIV_STAGES];
	assign hue                 = flat_c[DIV_STAGES] ? '0 : hue_quo_c[DIV_STAGES];
	assign saturation          = flat_c[DIV_STAGES] ? '0 : sat_quo_c[DIV_STAGES];

endmodule

`default_nettype wire
